/* rtl/segment_intersection_test_macros.svh */
// ---------------------------------------------------------------------------
// Segment intersection test: assertion macros
// Shared concurrent assertion forms for the segment intersection test RTL.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define SIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent a fixed number of cycles later.
`define SIT_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SIT_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg)
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/sit_pkg.sv */
// ---------------------------------------------------------------------------
// Segment intersection test package
// Shared constants and types for the segment intersection test pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    // Default coordinate width.
    localparam int COORD_BITS_DEFAULT = 16;

    // Clock edges from the accepting edge to the edge that takes the result.
    localparam int LATENCY = 5;

    // Relation between the two carrier lines.
    typedef enum logic [1:0] {
        REL_CROSS    = 2'd0,
        REL_SAME     = 2'd1,
        REL_PARALLEL = 2'd2
    } relation_t;

endpackage

`default_nettype wire

/* rtl/sit_cross.sv */
// ---------------------------------------------------------------------------
// Segment intersection test: cross product unit
// Computes a*b - c*d in two register stages: products, then difference.
// ---------------------------------------------------------------------------
`default_nettype none

module sit_cross #(
    parameter int IN_BITS = 17
) (
    input  wire logic                         clk,
    input  wire logic signed [IN_BITS-1:0]    a,
    input  wire logic signed [IN_BITS-1:0]    b,
    input  wire logic signed [IN_BITS-1:0]    c,
    input  wire logic signed [IN_BITS-1:0]    d,
    output logic signed [2*IN_BITS:0]         result
);

    localparam int PW = 2 * IN_BITS;
    localparam int RW = 2 * IN_BITS + 1;

    logic signed [PW-1:0] prod_ab_reg, prod_ab_next;
    logic signed [PW-1:0] prod_cd_reg, prod_cd_next;
    logic signed [RW-1:0] diff_reg, diff_next;

    // Both products of the cross term.
    always_comb
    begin
        prod_ab_next = PW'(a) * PW'(b);
        prod_cd_next = PW'(c) * PW'(d);
    end

    // Difference one bit wider than a product, so it never overflows.
    always_comb
    begin
        diff_next = RW'(prod_ab_reg) - RW'(prod_cd_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_ab_reg <= prod_ab_next;
        prod_cd_reg <= prod_cd_next;
        diff_reg    <= diff_next;
    end

    assign result = diff_reg;

endmodule

`default_nettype wire

/* rtl/segment_intersection_test.sv */
// ---------------------------------------------------------------------------
// Segment intersection test
// Exact integer test of whether two 2D segments share a point.
// ---------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy stays low, so one pair
// of segments can enter on every clock. The result strobe done is registered
// together with the result, in the last stage, and stays high for one cycle;
// the receiver must take it then. The five register stages are: differences
// and bounding box compares, the multipliers of the cross products, their
// subtraction, sign normalization of the line parameters, and the final range
// checks. relation reports 0 for lines crossing at one point, 1 for the same
// line and 2 for parallel distinct lines. A zero-length segment is taken as
// vertical. No state is kept between transactions.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segment_intersection_test_macros.svh"

module segment_intersection_test #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] first_start_x,
    input  wire logic signed [COORD_BITS-1:0] first_start_y,
    input  wire logic signed [COORD_BITS-1:0] first_end_x,
    input  wire logic signed [COORD_BITS-1:0] first_end_y,
    input  wire logic signed [COORD_BITS-1:0] second_start_x,
    input  wire logic signed [COORD_BITS-1:0] second_start_y,
    input  wire logic signed [COORD_BITS-1:0] second_end_x,
    input  wire logic signed [COORD_BITS-1:0] second_end_y,
    output logic                              done,
    output logic                              intersects,
    output logic [1:0]                        relation
);

    localparam int DW = COORD_BITS + 1;
    localparam int XW = 2 * DW + 1;

    // Stage 1: direction and offset vectors, degenerate flags, box hit.
    logic                 s1_valid_reg, s1_valid_next;
    logic signed [DW-1:0] s1_ua_x_reg, s1_ua_x_next;
    logic signed [DW-1:0] s1_ua_y_reg, s1_ua_y_next;
    logic signed [DW-1:0] s1_ub_x_reg, s1_ub_x_next;
    logic signed [DW-1:0] s1_ub_y_reg, s1_ub_y_next;
    logic signed [DW-1:0] s1_w_x_reg, s1_w_x_next;
    logic signed [DW-1:0] s1_w_y_reg, s1_w_y_next;
    logic                 s1_a_point_reg, s1_a_point_next;
    logic                 s1_b_point_reg, s1_b_point_next;
    logic                 s1_box_reg, s1_box_next;

    logic signed [DW-1:0] dax, day, dbx, dby;

    // Stages 2 and 3: flags travel alongside the cross product units.
    logic                 s2_valid_reg, s3_valid_reg;
    logic                 s2_a_point_reg, s3_a_point_reg;
    logic                 s2_b_point_reg, s3_b_point_reg;
    logic                 s2_box_reg, s3_box_reg;

    logic signed [XW-1:0] den, tn, sn;

    // Stage 4: normalized parameter ratios.
    logic                 s4_valid_reg;
    logic                 s4_den_zero_reg, s4_den_zero_next;
    logic                 s4_sn_zero_reg, s4_sn_zero_next;
    logic                 s4_tn_zero_reg, s4_tn_zero_next;
    logic signed [XW-1:0] s4_den_reg, s4_den_next;
    logic signed [XW-1:0] s4_tn_reg, s4_tn_next;
    logic signed [XW-1:0] s4_sn_reg, s4_sn_next;
    logic                 s4_a_point_reg, s4_b_point_reg, s4_box_reg;

    // Stage 5: result registers.
    logic                 done_reg;
    logic                 intersects_reg, intersects_next;
    sit_pkg::relation_t   relation_reg, relation_next;

    logic                 accept;
    logic                 on_a, on_b;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Inclusive bounding-box membership without forming min and max.
    function automatic logic in_box(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] c1x,
        input logic signed [COORD_BITS-1:0] c1y,
        input logic signed [COORD_BITS-1:0] c2x,
        input logic signed [COORD_BITS-1:0] c2y
    );
        return (px >= c1x || px >= c2x) && (px <= c1x || px <= c2x) &&
               (py >= c1y || py >= c2y) && (py <= c1y || py <= c2y);
    endfunction

    // Stage 1 logic: vectors, zero-length substitution and the box test.
    always_comb
    begin
        dax = DW'(first_end_x) - DW'(first_start_x);
        day = DW'(first_end_y) - DW'(first_start_y);
        dbx = DW'(second_end_x) - DW'(second_start_x);
        dby = DW'(second_end_y) - DW'(second_start_y);

        s1_valid_next   = accept;
        s1_a_point_next = (dax == '0) && (day == '0);
        s1_b_point_next = (dbx == '0) && (dby == '0);
        s1_ua_x_next    = dax;
        s1_ub_x_next    = dbx;
        s1_ua_y_next    = s1_a_point_next ? DW'(1) : day;
        s1_ub_y_next    = s1_b_point_next ? DW'(1) : dby;
        s1_w_x_next     = DW'(second_start_x) - DW'(first_start_x);
        s1_w_y_next     = DW'(second_start_y) - DW'(first_start_y);

        s1_box_next =
            in_box(first_start_x, first_start_y, second_start_x, second_start_y,
                   second_end_x, second_end_y) ||
            in_box(first_end_x, first_end_y, second_start_x, second_start_y,
                   second_end_x, second_end_y) ||
            in_box(second_start_x, second_start_y, first_start_x, first_start_y,
                   first_end_x, first_end_y) ||
            in_box(second_end_x, second_end_y, first_start_x, first_start_y,
                   first_end_x, first_end_y);
    end

    // Cross products: den = ua x ub, tn = w x ub, sn = w x ua.
    sit_cross #(
        .IN_BITS (DW)
    ) u_cross_den (
        .clk    (clk),
        .a      (s1_ua_x_reg),
        .b      (s1_ub_y_reg),
        .c      (s1_ua_y_reg),
        .d      (s1_ub_x_reg),
        .result (den)
    );

    sit_cross #(
        .IN_BITS (DW)
    ) u_cross_tn (
        .clk    (clk),
        .a      (s1_w_x_reg),
        .b      (s1_ub_y_reg),
        .c      (s1_w_y_reg),
        .d      (s1_ub_x_reg),
        .result (tn)
    );

    sit_cross #(
        .IN_BITS (DW)
    ) u_cross_sn (
        .clk    (clk),
        .a      (s1_w_x_reg),
        .b      (s1_ua_y_reg),
        .c      (s1_w_y_reg),
        .d      (s1_ua_x_reg),
        .result (sn)
    );

    // Stage 4 logic: flip signs so that the denominator is not negative.
    always_comb
    begin
        s4_den_zero_next = (den == '0);
        s4_sn_zero_next  = (sn == '0);
        s4_tn_zero_next  = (tn == '0);
        if (den[XW-1])
        begin
            s4_den_next = -den;
            s4_tn_next  = -tn;
            s4_sn_next  = -sn;
        end
        else
        begin
            s4_den_next = den;
            s4_tn_next  = tn;
            s4_sn_next  = sn;
        end
    end

    // Stage 5 logic: classify the lines and check both parameter ranges.
    always_comb
    begin
        on_a = s4_a_point_reg ? s4_tn_zero_reg
                              : (!s4_tn_reg[XW-1] && (s4_tn_reg <= s4_den_reg));
        on_b = s4_b_point_reg ? s4_sn_zero_reg
                              : (!s4_sn_reg[XW-1] && (s4_sn_reg <= s4_den_reg));
        if (!s4_den_zero_reg)
        begin
            relation_next   = sit_pkg::REL_CROSS;
            intersects_next = on_a && on_b;
        end
        else if (s4_sn_zero_reg)
        begin
            relation_next   = sit_pkg::REL_SAME;
            intersects_next = s4_box_reg;
        end
        else
        begin
            relation_next   = sit_pkg::REL_PARALLEL;
            intersects_next = 1'b0;
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        s1_ua_x_reg     <= s1_ua_x_next;
        s1_ua_y_reg     <= s1_ua_y_next;
        s1_ub_x_reg     <= s1_ub_x_next;
        s1_ub_y_reg     <= s1_ub_y_next;
        s1_w_x_reg      <= s1_w_x_next;
        s1_w_y_reg      <= s1_w_y_next;
        s1_a_point_reg  <= s1_a_point_next;
        s1_b_point_reg  <= s1_b_point_next;
        s1_box_reg      <= s1_box_next;

        s2_a_point_reg  <= s1_a_point_reg;
        s2_b_point_reg  <= s1_b_point_reg;
        s2_box_reg      <= s1_box_reg;
        s3_a_point_reg  <= s2_a_point_reg;
        s3_b_point_reg  <= s2_b_point_reg;
        s3_box_reg      <= s2_box_reg;

        s4_den_zero_reg <= s4_den_zero_next;
        s4_sn_zero_reg  <= s4_sn_zero_next;
        s4_tn_zero_reg  <= s4_tn_zero_next;
        s4_den_reg      <= s4_den_next;
        s4_tn_reg       <= s4_tn_next;
        s4_sn_reg       <= s4_sn_next;
        s4_a_point_reg  <= s3_a_point_reg;
        s4_b_point_reg  <= s3_b_point_reg;
        s4_box_reg      <= s3_box_reg;

        intersects_reg  <= intersects_next;
        relation_reg    <= relation_next;
    end

    assign done       = done_reg;
    assign intersects = intersects_reg;
    assign relation   = relation_reg;

    // Every accepted transaction yields its strobe after the fixed latency.
    `SIT_ASSERT_DELAY(a_latency, clk, rst_n, accept, sit_pkg::LATENCY, done,
        "result strobe missing after accepted transaction")

    // No strobe without a transaction accepted the fixed latency earlier.
    `SIT_ASSERT_IMPL(a_no_spurious, clk, rst_n, done, $past(accept, sit_pkg::LATENCY),
        "result strobe without an accepted transaction")

    // Parallel distinct lines never report an intersection.
    `SIT_ASSERT_IMPL(a_parallel_miss, clk, rst_n,
        done && (relation == sit_pkg::REL_PARALLEL), !intersects,
        "parallel distinct lines reported as intersecting")

    // A nonzero denominator always classifies as crossing lines.
    `SIT_ASSERT_NEXT(a_cross_class, clk, rst_n, s4_valid_reg && !s4_den_zero_reg,
        relation == sit_pkg::REL_CROSS,
        "nonzero denominator not classified as crossing")

endmodule

`default_nettype wire

/* tb/sv/tb_segment_intersection_test.sv */
// ---------------------------------------------------------------------------
// Segment intersection test: self-checking testbench
// Drives pairs of 2D segments into the block and checks each result strobe
// against an exact integer model of the crossing, collinear and parallel
// cases. A directed set of corner cases comes first, then random pairs,
// with random idle gaps on the sending side.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_intersection_test;

    localparam int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One input transaction: two segments.
    typedef struct {
        coord_t first_start_x;
        coord_t first_start_y;
        coord_t first_end_x;
        coord_t first_end_y;
        coord_t second_start_x;
        coord_t second_start_y;
        coord_t second_end_x;
        coord_t second_end_y;
    } seg_pair_t;

    // One result transaction.
    typedef struct {
        logic               intersects;
        sit_pkg::relation_t relation;
    } pair_verdict_t;

    logic   clk            = 1'b0;
    logic   rst_n          = 1'b0;
    logic   start          = 1'b0;
    coord_t first_start_x  = '0;
    coord_t first_start_y  = '0;
    coord_t first_end_x    = '0;
    coord_t first_end_y    = '0;
    coord_t second_start_x = '0;
    coord_t second_start_y = '0;
    coord_t second_end_x   = '0;
    coord_t second_end_y   = '0;

    logic       busy;
    logic       done;
    logic       intersects;
    logic [1:0] relation;

    seg_pair_t     pending_pairs[$];
    pair_verdict_t expected_verdicts[$];
    seg_pair_t     cur_pair;
    int            total_items    = 0;
    int            accepted_count = 0;
    int            error_count    = 0;
    int            idle_left      = 0;
    int            burst_left     = 0;

    segment_intersection_test #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_start_x (first_start_x),
        .first_start_y (first_start_y),
        .first_end_x   (first_end_x),
        .first_end_y   (first_end_y),
        .second_start_x(second_start_x),
        .second_start_y(second_start_y),
        .second_end_x  (second_end_x),
        .second_end_y  (second_end_y),
        .done          (done),
        .intersects    (intersects),
        .relation      (relation)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // True if point (px,py) lies in the box spanned by two corners, inclusive.
    function automatic bit box_holds(longint px, longint py, longint c1x, longint c1y,
                                     longint c2x, longint c2y);
        return (px >= ((c1x < c2x) ? c1x : c2x)) && (px <= ((c1x > c2x) ? c1x : c2x)) &&
               (py >= ((c1y < c2y) ? c1y : c2y)) && (py <= ((c1y > c2y) ? c1y : c2y));
    endfunction

    // True if num/den lies in [0,1]; den is nonzero.
    function automatic bit ratio_in_unit(longint num, longint den);
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        return (num >= 0) && (num <= den);
    endfunction

    // Exact classification of a segment pair.
    function automatic pair_verdict_t classify_pair(seg_pair_t p);
        longint        ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint        dax, day, dbx, dby, wx, wy, den, tn, sn;
        bit            a_pt, b_pt, on_a, on_b;
        pair_verdict_t v;
        ax0 = p.first_start_x;
        ay0 = p.first_start_y;
        ax1 = p.first_end_x;
        ay1 = p.first_end_y;
        bx0 = p.second_start_x;
        by0 = p.second_start_y;
        bx1 = p.second_end_x;
        by1 = p.second_end_y;
        dax = ax1 - ax0;
        day = ay1 - ay0;
        dbx = bx1 - bx0;
        dby = by1 - by0;
        // A zero-length segment lies on the vertical line through its point.
        a_pt = (dax == 0) && (day == 0);
        b_pt = (dbx == 0) && (dby == 0);
        if (a_pt)
        begin
            dax = 0;
            day = 1;
        end
        if (b_pt)
        begin
            dbx = 0;
            dby = 1;
        end
        wx  = bx0 - ax0;
        wy  = by0 - ay0;
        den = dax * dby - day * dbx;
        if (den == 0)
        begin
            if (dax * wy - day * wx == 0)
            begin
                v.relation   = sit_pkg::REL_SAME;
                v.intersects = box_holds(ax0, ay0, bx0, by0, bx1, by1) ||
                               box_holds(ax1, ay1, bx0, by0, bx1, by1) ||
                               box_holds(bx0, by0, ax0, ay0, ax1, ay1) ||
                               box_holds(bx1, by1, ax0, ay0, ax1, ay1);
            end
            else
            begin
                v.relation   = sit_pkg::REL_PARALLEL;
                v.intersects = 1'b0;
            end
        end
        else
        begin
            tn   = wx * dby - wy * dbx;
            sn   = wx * day - wy * dax;
            on_a = a_pt ? (tn == 0) : ratio_in_unit(tn, den);
            on_b = b_pt ? (sn == 0) : ratio_in_unit(sn, den);
            v.relation   = sit_pkg::REL_CROSS;
            v.intersects = on_a && on_b;
        end
        return v;
    endfunction

    // Queue one pair; coordinates are cut to the port width.
    function automatic void add_pair(int fsx, int fsy, int fex, int fey,
                                     int ssx, int ssy, int sex, int sey);
        seg_pair_t p;
        p.first_start_x  = coord_t'(fsx);
        p.first_start_y  = coord_t'(fsy);
        p.first_end_x    = coord_t'(fex);
        p.first_end_y    = coord_t'(fey);
        p.second_start_x = coord_t'(ssx);
        p.second_start_y = coord_t'(ssy);
        p.second_end_x   = coord_t'(sex);
        p.second_end_y   = coord_t'(sey);
        pending_pairs.push_back(p);
    endfunction

    // A coordinate at or next to the ends of the signed range, or near zero.
    function automatic int pick_corner();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    // Driver: presents queued pairs with random idle gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_verdicts.push_back(classify_pair(cur_pair));
                accepted_count++;
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    cur_pair = pending_pairs.pop_front();
                    first_start_x  <= cur_pair.first_start_x;
                    first_start_y  <= cur_pair.first_start_y;
                    first_end_x    <= cur_pair.first_end_x;
                    first_end_y    <= cur_pair.first_end_y;
                    second_start_x <= cur_pair.second_start_x;
                    second_start_y <= cur_pair.second_start_y;
                    second_end_x   <= cur_pair.second_end_x;
                    second_end_y   <= cur_pair.second_end_y;
                    start          <= 1'b1;
                    // Gap before the next transaction, with occasional back-to-back bursts.
                    if (burst_left > 0)
                    begin
                        burst_left--;
                        idle_left = 0;
                    end
                    else if ($urandom_range(0, 19) == 0)
                    begin
                        burst_left = $urandom_range(8, 40);
                        idle_left  = 0;
                    end
                    else
                    begin
                        idle_left = $urandom_range(0, 9);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result strobe against the oldest expectation.
    always @(posedge clk)
    begin
        pair_verdict_t exp_v;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result intersects=%0b relation=%0d",
                                          intersects, relation));
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (intersects !== exp_v.intersects)
                    report_mismatch($sformatf("intersects got %0b, expected %0b",
                                              intersects, exp_v.intersects));
                if (relation !== exp_v.relation)
                    report_mismatch($sformatf("relation got %0d, expected %s",
                                              relation, exp_v.relation.name()));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int bx, by, dx, dy, ox, oy, m, j, k0, k1, k2, k3;

        // Directed corner cases.
        add_pair(-10, -10, 10, 10, -10, 10, 10, -10);      // proper crossing
        add_pair(0, 0, 1, 1, 5, 0, 4, 1);                  // lines cross outside both
        add_pair(0, 0, 10, 0, 5, 0, 5, 7);                 // T touching at an endpoint
        add_pair(0, 0, 4, 4, 4, 4, 8, 0);                  // shared endpoint
        add_pair(0, 0, 10, 10, 5, 5, 15, 15);              // collinear overlap
        add_pair(0, 0, 2, 2, 5, 5, 9, 9);                  // collinear disjoint
        add_pair(0, 0, 3, 3, 3, 3, 6, 6);                  // collinear touching
        add_pair(0, 0, 10, 0, 2, 0, 4, 0);                 // collinear containment
        add_pair(0, 0, 10, 0, 0, 1, 10, 1);                // parallel distinct
        add_pair(3, 4, 3, 4, 3, 4, 3, 4);                  // two equal points
        add_pair(3, 4, 3, 4, 3, 9, 3, 9);                  // two points on one vertical
        add_pair(3, 4, 3, 4, 5, 4, 5, 4);                  // two points, different x
        add_pair(2, 0, 2, 0, 0, 0, 10, 0);                 // point on a segment
        add_pair(12, 0, 12, 0, 0, 0, 10, 0);               // point on line, off segment
        add_pair(2, 1, 2, 1, 0, 0, 10, 0);                 // point off the line
        add_pair(0, 5, 0, 5, 0, 0, 0, 10);                 // point on a vertical segment
        add_pair(0, 20, 0, 20, 0, 0, 0, 10);               // point beyond a vertical segment
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
        add_pair(0, 0, 10, 10, 6, 5, 20, 5);               // near miss
        add_pair(10, 10, -10, -10, 10, -10, -10, 10);      // reversed directions
        add_pair(10, 0, 0, 0, 15, 0, 5, 0);                // reversed collinear overlap
        add_pair(32767, -32768, -32768, 32767, 0, 0, -1, -1);

        // Random pairs, mostly shaped to land on the interesting relations.
        repeat (500)
        begin
            bx = $urandom_range(0, 2000) - 1000;
            by = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 100) - 50;
            dy = $urandom_range(0, 100) - 50;
            k0 = $urandom_range(0, 40) - 20;
            k1 = $urandom_range(0, 40) - 20;
            k2 = $urandom_range(0, 40) - 20;
            k3 = $urandom_range(0, 40) - 20;
            ox = $urandom_range(0, 20) - 10;
            oy = $urandom_range(0, 20) - 10;
            m  = $urandom_range(0, 10);
            j  = $urandom_range(0, m + 4) - 2;
            case ($urandom_range(0, 9))
                0, 1:
                    // Full-range noise.
                    add_pair($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
                2, 3:
                    // Small coordinates, where crossings are common.
                    add_pair($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                             $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                             $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                             $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
                4, 5:
                    // Four points on one line.
                    add_pair(bx + k0 * dx, by + k0 * dy, bx + k1 * dx, by + k1 * dy,
                             bx + k2 * dx, by + k2 * dy, bx + k3 * dx, by + k3 * dy);
                6:
                    // Parallel copy, sometimes on the same line.
                    add_pair(bx + k0 * dx, by + k0 * dy, bx + k1 * dx, by + k1 * dy,
                             bx + ox + k2 * dx, by + oy + k2 * dy,
                             bx + ox + k3 * dx, by + oy + k3 * dy);
                7:
                    // Second segment starts on or near the first one.
                    add_pair(bx, by, bx + m * dx, by + m * dy,
                             bx + j * dx, by + j * dy, bx + j * dx + oy, by + j * dy + ox);
                8:
                    // Zero-length first segment near or on the second.
                    add_pair(bx + j * dx, by + j * dy + (ox == 0 ? oy : 0),
                             bx + j * dx, by + j * dy + (ox == 0 ? oy : 0),
                             bx, by, bx + m * dx, by + m * dy);
                default:
                    // Coordinates at the ends of the range.
                    add_pair(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                             pick_corner(), pick_corner(), pick_corner(), pick_corner());
            endcase
        end
        total_items = pending_pairs.size();

        // Hold reset at the start of the run, then release it.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to be taken and every result to come back.
        while (accepted_count < total_items || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (sit_pkg::LATENCY + 4) @(posedge clk);

        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_cross.sv
rtl/segment_intersection_test.sv
tb/sv/tb_segment_intersection_test.sv
